/* design/periodic_hessian_stencil_assert.svh */
// Assertion macros used by the periodic Hessian stencil module.
`ifndef PERIODIC_HESSIAN_STENCIL_ASSERT_SVH
`define PERIODIC_HESSIAN_STENCIL_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checks the consequent in the same cycle as the antecedent.
`define PHS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("phs assertion failed");
// Checks the consequent in the cycle after the antecedent.
`define PHS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("phs assertion failed");
`else
`define PHS_ASSERT_NOW(lbl, ante, cons)
`define PHS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* design/phs_pkg.sv */
// Shared types and constants of the periodic Hessian stencil block.
`timescale 1ns / 1ps
package phs_pkg;

  localparam int SIZE_W  = 6;
  localparam int AXIS_W  = 2;
  localparam int COORD_W = 5;
  localparam int DATA_W  = 32;
  localparam int SUM_W   = 35;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_AXIS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_AXIS = 3'd4;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  localparam logic [AXIS_W-1:0] AXIS_X     = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y     = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z     = 2'd2;
  localparam logic [AXIS_W-1:0] AXIS_ALT_Z = 2'd3;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DRAIN,
    ST_EMIT
  } phs_state_t;

  // Neighbor step applied by the address generator.
  typedef struct packed {
    logic en;
    logic up_a;
    logic up_b;
  } phs_step_t;

  // Control of the shared accumulator.
  typedef struct packed {
    logic clr;
    logic en;
    logic sub;
  } phs_acc_ctl_t;

endpackage

/* design/periodic_hessian_stencil.sv */
// Periodic central-difference Hessian element engine over a loaded 3D volume.
// Load items are accepted back to back; a load produces no result.
// A compute item reads four stencil points through the single volume port, one per
// cycle in FETCH, then passes through DRAIN to EMIT; no new item is taken until EMIT
// has passed its result to the output register. An out-of-range compute goes to EMIT.
// rst_n is synchronous; it restores the size and axis registers, the volume is not cleared.
`timescale 1ns / 1ps
`include "periodic_hessian_stencil_assert.svh"
module periodic_hessian_stencil #(
  parameter int MAX_X = 32,
  parameter int MAX_Y = 32,
  parameter int MAX_Z = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // sample[31:0], coord_x[36:32], coord_y[41:37], coord_z[46:42], zero[47]
  input  logic [47:0]                       in_tdata,
  // cmd[0]
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // derivative[31:0]
  output logic [phs_pkg::DATA_W-1:0]        out_tdata,
  // range_error[0]
  output logic                              out_tuser,
  input  logic                              cfg_we,
  input  logic [phs_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [phs_pkg::SIZE_W-1:0]        cfg_wdata
);
  import phs_pkg::*;

  localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [1:0] K_LAST = 2'd3;

  logic [SIZE_W-1:0] size_x_r, size_y_r, size_z_r;
  logic [AXIS_W-1:0] first_axis_r, second_axis_r;
  logic [SIZE_W-1:0] n_x, n_y, n_z;

  phs_state_t state_r, state_nxt;
  logic [1:0] k_r, k_nxt;
  logic       pend_r, pend_sub_r;
  logic       err_r;
  logic [COORD_W-1:0] cx_r, cy_r, cz_r;

  logic              out_tvalid_r;
  logic [DATA_W-1:0] out_data_r;
  logic              out_err_r;

  logic [DATA_W-1:0]  in_sample;
  logic [COORD_W-1:0] in_x, in_y, in_z;
  logic               in_acc, in_range, out_free, load_out, ram_we;

  logic [SIZE_W-1:0]   cur_x, cur_y, cur_z;
  phs_step_t           step;
  phs_acc_ctl_t        acc_ctl;
  logic [AW-1:0]       ram_addr;
  logic [DATA_W-1:0]   ram_rdata;
  logic signed [DATA_W-1:0] acc_result;

  assign in_sample = in_tdata[31:0];
  assign in_x      = in_tdata[36:32];
  assign in_y      = in_tdata[41:37];
  assign in_z      = in_tdata[46:42];

  // A size above the volume extent acts as that extent.
  assign n_x = ({3'b000, size_x_r} > 9'(MAX_X)) ? SIZE_W'(MAX_X) : size_x_r;
  assign n_y = ({3'b000, size_y_r} > 9'(MAX_Y)) ? SIZE_W'(MAX_Y) : size_y_r;
  assign n_z = ({3'b000, size_z_r} > 9'(MAX_Z)) ? SIZE_W'(MAX_Z) : size_z_r;

  assign in_range = ({1'b0, in_x} < n_x) && ({1'b0, in_y} < n_y) && ({1'b0, in_z} < n_z);
  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r      <= SIZE_RESET;
      size_y_r      <= SIZE_RESET;
      size_z_r      <= SIZE_RESET;
      first_axis_r  <= AXIS_X;
      second_axis_r <= AXIS_X;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SIZE_X:      size_x_r      <= cfg_wdata;
        REG_SIZE_Y:      size_y_r      <= cfg_wdata;
        REG_SIZE_Z:      size_z_r      <= cfg_wdata;
        REG_FIRST_AXIS:  first_axis_r  <= cfg_wdata[AXIS_W-1:0];
        REG_SECOND_AXIS: second_axis_r <= cfg_wdata[AXIS_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_tuser == CMD_COMPUTE) begin
          state_nxt = in_range ? ST_FETCH : ST_EMIT;
        end
      end
      ST_FETCH: begin
        if (k_r == K_LAST) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_tready = 1'b0;
    load_out  = 1'b0;
    step      = '0;
    k_nxt     = '0;
    unique case (state_r)
      ST_IDLE:  in_tready = 1'b1;
      ST_FETCH: begin
        step.en   = 1'b1;
        step.up_a = !k_r[0];
        step.up_b = !k_r[1];
        k_nxt     = k_r + 2'd1;
      end
      ST_DRAIN: ;
      ST_EMIT:  load_out = out_free;
      default: ;
    endcase
  end

  assign ram_we      = in_acc && in_tuser == CMD_LOAD && in_range;
  // Stencil signs: ++ and -- add, mixed steps subtract.
  assign acc_ctl.clr = in_acc && in_tuser == CMD_COMPUTE;
  assign acc_ctl.en  = pend_r;
  assign acc_ctl.sub = pend_sub_r;

  assign cur_x = (state_r == ST_IDLE) ? {1'b0, in_x} : {1'b0, cx_r};
  assign cur_y = (state_r == ST_IDLE) ? {1'b0, in_y} : {1'b0, cy_r};
  assign cur_z = (state_r == ST_IDLE) ? {1'b0, in_z} : {1'b0, cz_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      k_r          <= '0;
      pend_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      k_r          <= k_nxt;
      pend_r       <= (state_r == ST_FETCH);
      out_tvalid_r <= load_out ? 1'b1 : (out_tvalid_r && !out_tready);
    end
  end

  always_ff @(posedge clk) begin
    pend_sub_r <= k_r[0] ^ k_r[1];
    if (acc_ctl.clr) begin
      cx_r  <= in_x;
      cy_r  <= in_y;
      cz_r  <= in_z;
      err_r <= !in_range;
    end
    if (load_out) begin
      out_data_r <= err_r ? '0 : acc_result;
      out_err_r  <= err_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_err_r;

  phs_addr #(
    .MAX_X(MAX_X),
    .MAX_Y(MAX_Y),
    .MAX_Z(MAX_Z)
  ) u_addr (
    .coord_x (cur_x),
    .coord_y (cur_y),
    .coord_z (cur_z),
    .size_x  (n_x),
    .size_y  (n_y),
    .size_z  (n_z),
    .axis_a  (first_axis_r),
    .axis_b  (second_axis_r),
    .step    (step),
    .addr    (ram_addr)
  );

  phs_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_volume (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_sample),
    .rdata (ram_rdata)
  );

  phs_acc u_acc (
    .clk    (clk),
    .ctl    (acc_ctl),
    .rdata  ($signed(ram_rdata)),
    .result (acc_result)
  );

  `PHS_ASSERT_NEXT(a_fetch_to_drain, state_r == ST_FETCH && k_r == K_LAST, state_r == ST_DRAIN)
  `PHS_ASSERT_NEXT(a_read_data_follows, state_r == ST_FETCH, pend_r)
  `PHS_ASSERT_NEXT(a_compute_starts, acc_ctl.clr && in_range, state_r == ST_FETCH)
  `PHS_ASSERT_NOW(a_error_zero, out_tvalid && out_tuser, out_tdata == '0)
  `PHS_ASSERT_NOW(a_write_only_idle, ram_we, state_r == ST_IDLE)

endmodule

/* design/phs_ram.sv */
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
module phs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

/* design/phs_addr.sv */
// Volume address generator with periodic neighbor steps on two axes.
`timescale 1ns / 1ps
module phs_addr #(
  parameter int MAX_X = 32,
  parameter int MAX_Y = 32,
  parameter int MAX_Z = 32,
  localparam int DEPTH = MAX_X * MAX_Y * MAX_Z,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic [phs_pkg::SIZE_W-1:0] coord_x,
  input  logic [phs_pkg::SIZE_W-1:0] coord_y,
  input  logic [phs_pkg::SIZE_W-1:0] coord_z,
  input  logic [phs_pkg::SIZE_W-1:0] size_x,
  input  logic [phs_pkg::SIZE_W-1:0] size_y,
  input  logic [phs_pkg::SIZE_W-1:0] size_z,
  input  logic [phs_pkg::AXIS_W-1:0] axis_a,
  input  logic [phs_pkg::AXIS_W-1:0] axis_b,
  input  phs_pkg::phs_step_t         step,
  output logic [AW-1:0]              addr
);
  import phs_pkg::*;

  logic [SIZE_W-1:0] c  [3];
  logic [SIZE_W-1:0] n  [3];
  logic [SIZE_W-1:0] p1 [3];
  logic [SIZE_W-1:0] p2 [3];
  logic [AXIS_W-1:0] a_eff;
  logic [AXIS_W-1:0] b_eff;

  function automatic logic [SIZE_W-1:0] wrap_step(input logic [SIZE_W-1:0] cv,
                                                  input logic [SIZE_W-1:0] nv,
                                                  input logic up);
    logic [SIZE_W:0] inc;
    inc = (SIZE_W+1)'(cv) + (SIZE_W+1)'(1);
    if (up) begin
      return (inc >= (SIZE_W+1)'(nv)) ? '0 : inc[SIZE_W-1:0];
    end
    return (cv == '0) ? nv - SIZE_W'(1) : cv - SIZE_W'(1);
  endfunction

  assign c[0] = coord_x;
  assign c[1] = coord_y;
  assign c[2] = coord_z;
  assign n[0] = size_x;
  assign n[1] = size_y;
  assign n[2] = size_z;

  // The unused axis code selects z.
  assign a_eff = (axis_a == AXIS_ALT_Z) ? AXIS_Z : axis_a;
  assign b_eff = (axis_b == AXIS_ALT_Z) ? AXIS_Z : axis_b;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p1[i] = (step.en && a_eff == AXIS_W'(i)) ? wrap_step(c[i], n[i], step.up_a) : c[i];
    end
    for (int i = 0; i < 3; i++) begin
      p2[i] = (step.en && b_eff == AXIS_W'(i)) ? wrap_step(p1[i], n[i], step.up_b) : p1[i];
    end
  end

  assign addr = AW'((32'(p2[0]) * 32'(MAX_Y) + 32'(p2[1])) * 32'(MAX_Z) + 32'(p2[2]));

endmodule

/* design/phs_acc.sv */
// Shared add/subtract accumulator with rounding divide by four and saturation.
`timescale 1ns / 1ps
module phs_acc (
  input  logic                               clk,
  input  phs_pkg::phs_acc_ctl_t              ctl,
  input  logic signed [phs_pkg::DATA_W-1:0]  rdata,
  output logic signed [phs_pkg::DATA_W-1:0]  result
);
  import phs_pkg::*;

  localparam logic signed [SUM_W-3:0] Q_MAX = {2'b00, {31{1'b1}}};
  localparam logic signed [SUM_W-3:0] Q_MIN = {2'b11, 31'b0};

  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W-1:0] sum_nxt;
  logic signed [SUM_W-1:0] operand;
  logic signed [SUM_W-1:0] biased;
  logic signed [SUM_W-3:0] quo;

  assign operand = SUM_W'(rdata);

  always_comb begin
    sum_nxt = sum_r;
    if (ctl.clr) begin
      sum_nxt = '0;
    end else if (ctl.en) begin
      sum_nxt = ctl.sub ? sum_r - operand : sum_r + operand;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
  end

  // Adding two before the arithmetic shift rounds to nearest, ties upward.
  assign biased = sum_r + SUM_W'(2);
  assign quo    = $signed(biased[SUM_W-1:2]);

  always_comb begin
    if (quo > Q_MAX) begin
      result = 32'sh7FFF_FFFF;
    end else if (quo < Q_MIN) begin
      result = 32'sh8000_0000;
    end else begin
      result = $signed(quo[DATA_W-1:0]);
    end
  end

endmodule
